>>> rtl/pts_pkg.sv
package pts_pkg;

  // Field widths of the two channels
  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned PERIOD_W   = 32;
  localparam int unsigned SLOT_W     = 3;
  localparam int unsigned FIRED_W    = 8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK      = 2'd0,
    OP_SET       = 2'd1,
    OP_CLEAR     = 2'd2,
    OP_CLEAR_ALL = 2'd3
  } op_t;

endpackage

>>> rtl/pts_if.sv
interface pts_in_if;
  logic                           valid;
  logic                           ready;
  logic [pts_pkg::OPCODE_W-1:0]   opcode;
  logic [pts_pkg::PERIOD_W-1:0]   period;
  logic [pts_pkg::SLOT_W-1:0]     slot;

  modport source (output valid, output opcode, output period, output slot, input ready);
  modport sink   (input valid, input opcode, input period, input slot, output ready);
endinterface

interface pts_out_if;
  logic                           valid;
  logic                           ready;
  logic [pts_pkg::SLOT_W-1:0]     assigned_slot;
  logic                           set_failed;
  logic [pts_pkg::FIRED_W-1:0]    fired_mask;

  modport source (output valid, output assigned_slot, output set_failed, output fired_mask,
                  input ready);
  modport sink   (input valid, input assigned_slot, input set_failed, input fired_mask,
                  output ready);
endinterface

>>> rtl/periodic_timer_slot_table_unit.sv
// Channel   Dir  Payload                                      Beat taken when
// in_ch     in   opcode[1:0], period[31:0], slot[2:0]         valid && ready
// out_ch    out  assigned_slot[2:0], set_failed, fired_mask   valid && ready
//
// One result beat per input beat; one beat a cycle sustained while out_ch.ready
// stays high. Each beat lands in an input register; one pass of logic (a
// decrementer per slot, a priority encoder for the free slot) then updates the
// table and loads the result register.
// Reset (rst_n low, synchronous) frees every slot and empties both registers.
// A stalled result holds the pass; the input register still takes one beat.
module periodic_timer_slot_table_unit #(
  parameter int unsigned NUM_SLOTS   = 8,
  parameter int unsigned PERIOD_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  pts_in_if.sink    in_ch,
  pts_out_if.source out_ch
);

  localparam int unsigned EXT_W = PERIOD_BITS + pts_pkg::PERIOD_W;

  // Input register
  logic                           in_vld_r;
  logic [pts_pkg::OPCODE_W-1:0]   in_op_r;
  logic [PERIOD_BITS-1:0]         in_period_r;
  logic [pts_pkg::SLOT_W-1:0]     in_slot_r;

  // Result register
  logic                           out_vld_r;
  logic [pts_pkg::SLOT_W-1:0]     out_slot_r;
  logic                           out_failed_r;
  logic [pts_pkg::FIRED_W-1:0]    out_fired_r;

  // Slot table
  logic [NUM_SLOTS-1:0]           active_r;
  logic [PERIOD_BITS-1:0]         reload_r    [NUM_SLOTS];
  logic [PERIOD_BITS-1:0]         remaining_r [NUM_SLOTS];

  logic [NUM_SLOTS-1:0]           active_nxt;
  logic [PERIOD_BITS-1:0]         reload_nxt    [NUM_SLOTS];
  logic [PERIOD_BITS-1:0]         remaining_nxt [NUM_SLOTS];
  logic [pts_pkg::SLOT_W-1:0]     out_slot_nxt;
  logic                           out_failed_nxt;
  logic [pts_pkg::FIRED_W-1:0]    out_fired_nxt;

  logic [NUM_SLOTS-1:0]           fired_all;
  logic [NUM_SLOTS+pts_pkg::FIRED_W-1:0] fired_ext;
  logic [PERIOD_BITS-1:0]         dec      [NUM_SLOTS];
  logic [EXT_W-1:0]               period_ext;
  logic                           found;
  logic                           advance;
  pts_pkg::op_t                   op;

  // The pass may run whenever the result register is free or being drained
  assign advance      = !out_vld_r || out_ch.ready;
  assign in_ch.ready  = !in_vld_r || advance;

  // Take the period modulo the counter width
  assign period_ext = {{PERIOD_BITS{1'b0}}, in_ch.period};

  assign op = pts_pkg::op_t'(in_op_r);

  always_comb begin
    active_nxt     = active_r;
    reload_nxt     = reload_r;
    remaining_nxt  = remaining_r;
    out_slot_nxt   = '0;
    out_failed_nxt = 1'b0;
    fired_all      = '0;
    found          = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      dec[i] = remaining_r[i] - PERIOD_BITS'(1);
    end
    case (op)
      pts_pkg::OP_TICK: begin
        // Count down every running slot; on reaching zero flag it and reload
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (active_r[i]) begin
            if (dec[i] == '0) begin
              fired_all[i]     = 1'b1;
              remaining_nxt[i] = reload_r[i];
            end else begin
              remaining_nxt[i] = dec[i];
            end
          end
        end
      end
      pts_pkg::OP_SET: begin
        // Claim the lowest free slot
        out_failed_nxt = 1'b1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!found && !active_r[i]) begin
            found            = 1'b1;
            active_nxt[i]    = 1'b1;
            reload_nxt[i]    = in_period_r;
            remaining_nxt[i] = in_period_r;
            out_slot_nxt     = pts_pkg::SLOT_W'(i);
            out_failed_nxt   = 1'b0;
          end
        end
      end
      pts_pkg::OP_CLEAR: begin
        // An index beyond the table matches no slot and is dropped
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (32'(in_slot_r) == i) begin
            active_nxt[i] = 1'b0;
          end
        end
      end
      pts_pkg::OP_CLEAR_ALL: begin
        active_nxt = '0;
      end
      default: begin
        active_nxt = active_r;
      end
    endcase
    fired_ext     = {{pts_pkg::FIRED_W{1'b0}}, fired_all};
    out_fired_nxt = fired_ext[pts_pkg::FIRED_W-1:0];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      active_r  <= '0;
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (advance) begin
        out_vld_r <= in_vld_r;
        if (in_vld_r) begin
          active_r <= active_nxt;
        end
      end
    end
  end

  // Payload and table contents
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_op_r     <= in_ch.opcode;
      in_period_r <= period_ext[PERIOD_BITS-1:0];
      in_slot_r   <= in_ch.slot;
    end
    if (advance && in_vld_r) begin
      reload_r     <= reload_nxt;
      remaining_r  <= remaining_nxt;
      out_slot_r   <= out_slot_nxt;
      out_failed_r <= out_failed_nxt;
      out_fired_r  <= out_fired_nxt;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.assigned_slot = out_slot_r;
  assign out_ch.set_failed    = out_failed_r;
  assign out_ch.fired_mask    = out_fired_r;

  // A clear-all leaves no slot running
  a_clear_all_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_vld_r && in_op_r == pts_pkg::OP_CLEAR_ALL) |=> (active_r == '0))
    else $error("slot still active after clear-all");

  // A set fails only when every slot is taken
  a_set_fail_full: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_vld_r && in_op_r == pts_pkg::OP_SET && active_r != '1)
      |=> (!out_failed_r && active_r != $past(active_r)))
    else $error("set failed with a free slot");

  // Only a tick result carries fired bits
  a_fired_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_vld_r && in_op_r != pts_pkg::OP_TICK) |=> (out_fired_r == '0))
    else $error("fired mask on a non-tick result");

endmodule

>>> dv/periodic_timer_slot_table_unit_tb.sv
`timescale 1ns / 100ps

module periodic_timer_slot_table_unit_tb;

  localparam int unsigned NUM_SLOTS    = 8;
  localparam int unsigned PERIOD_W     = pts_pkg::PERIOD_W;
  localparam int unsigned SLOT_W       = pts_pkg::SLOT_W;
  localparam int unsigned FIRED_W      = pts_pkg::FIRED_W;
  localparam int unsigned RANDOM_CMDS  = 1130;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned CYCLE_LIMIT  = 60000;

  typedef struct packed {
    pts_pkg::op_t        op;
    logic [PERIOD_W-1:0] period;
    logic [SLOT_W-1:0]   slot;
  } timer_cmd_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  assigned_slot;
    logic               set_failed;
    logic [FIRED_W-1:0] fired_mask;
  } timer_result_t;

  logic clk;
  logic rst_n;

  pts_in_if  in_ch ();
  pts_out_if out_ch ();

  periodic_timer_slot_table_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Local copy of the timer table, advanced once per accepted input beat
  logic                slot_busy  [NUM_SLOTS];
  logic [PERIOD_W-1:0] slot_period[NUM_SLOTS];
  logic [PERIOD_W-1:0] slot_count [NUM_SLOTS];

  timer_cmd_t    cmd_queue[$];        // commands waiting to be offered
  timer_result_t awaited_results[$];  // predicted result beats, oldest first

  timer_cmd_t    next_cmd;
  timer_result_t want;
  timer_result_t got;

  int unsigned errors;
  int unsigned cycles;
  int unsigned items_sent;
  int unsigned hold_left;
  logic        hold_done;
  logic        in_beat;
  logic        quiet;

  // Coverage tallies for the closing summary
  int unsigned n_tick, n_set, n_set_fail, n_fire, n_clear, n_clear_all;

  // No idling on either side while this window of items goes through
  assign quiet = (items_sent >= 500) && (items_sent < 700);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Apply one command to the local table and return the result it must produce
  function automatic timer_result_t timer_table_step(timer_cmd_t c);
    timer_result_t r;
    r = '0;
    case (c.op)
      pts_pkg::OP_TICK: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_busy[i]) begin
            slot_count[i] = slot_count[i] - 1'b1;
            if (slot_count[i] == '0) begin
              r.fired_mask[i] = 1'b1;
              slot_count[i]   = slot_period[i];
            end
          end
        end
      end
      pts_pkg::OP_SET: begin
        // lowest free slot wins; a full table flags failure
        r.set_failed = 1'b1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (r.set_failed && !slot_busy[i]) begin
            slot_busy[i]    = 1'b1;
            slot_period[i]  = c.period;
            slot_count[i]   = c.period;
            r.assigned_slot = SLOT_W'(i);
            r.set_failed    = 1'b0;
          end
        end
      end
      pts_pkg::OP_CLEAR: begin
        if (c.slot < NUM_SLOTS) slot_busy[c.slot] = 1'b0;
      end
      default: begin
        for (int i = 0; i < NUM_SLOTS; i++) slot_busy[i] = 1'b0;
      end
    endcase
    return r;
  endfunction

  function automatic logic [PERIOD_W-1:0] pick_period();
    int unsigned r;
    r = $urandom_range(99);
    // mostly short periods so that slots expire often; the rest cover every bit
    if (r < 78) return PERIOD_W'($urandom_range(8, 1));
    if (r < 88) return PERIOD_W'($urandom);
    if (r < 93) return '0;
    if (r < 97) return '1;
    return PERIOD_W'($urandom_range(40, 9));
  endfunction

  task automatic queue_cmd(pts_pkg::op_t op, logic [PERIOD_W-1:0] period,
                           logic [SLOT_W-1:0] slot);
    timer_cmd_t c;
    c.op     = op;
    c.period = period;
    c.slot   = slot;
    cmd_queue.push_back(c);
  endtask

  // Driver: hold the current beat until taken, then offer the next or idle
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_beat) begin
      if (cmd_queue.size() > 0 && (quiet || $urandom_range(99) >= 9)) begin
        next_cmd = cmd_queue.pop_front();
        in_ch.valid  <= 1'b1;
        in_ch.opcode <= next_cmd.op;
        in_ch.period <= next_cmd.period;
        in_ch.slot   <= next_cmd.slot;
        items_sent   <= items_sent + 1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, one long hold-off to back the block up, and a
  // stall-free window
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && items_sent >= HOLD_AT) begin
      out_ch.ready <= 1'b0;
      hold_done    <= 1'b1;
      hold_left    <= HOLD_CYCLES;
    end else begin
      out_ch.ready <= quiet || ($urandom_range(99) >= 9);
    end
  end

  // Monitor: check result beats against the oldest prediction, then predict
  // for the input beat taken at this edge
  always @(posedge clk) begin
    if (!rst_n) begin
      in_beat <= 1'b0;
    end else begin
      in_beat <= in_ch.valid && in_ch.ready;

      if (out_ch.valid && out_ch.ready) begin
        got.assigned_slot = out_ch.assigned_slot;
        got.set_failed    = out_ch.set_failed;
        got.fired_mask    = out_ch.fired_mask;
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result beat: slot %0d failed %0b fired %02h",
                   $time, got.assigned_slot, got.set_failed, got.fired_mask);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          if (got.assigned_slot !== want.assigned_slot) begin
            $display("%0t: assigned_slot mismatch: expected %0d, got %0d",
                     $time, want.assigned_slot, got.assigned_slot);
            errors++;
          end
          if (got.set_failed !== want.set_failed) begin
            $display("%0t: set_failed mismatch: expected %0b, got %0b",
                     $time, want.set_failed, got.set_failed);
            errors++;
          end
          if (got.fired_mask !== want.fired_mask) begin
            $display("%0t: fired_mask mismatch: expected %02h, got %02h",
                     $time, want.fired_mask, got.fired_mask);
            errors++;
          end
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        next_cmd.op     = pts_pkg::op_t'(in_ch.opcode);
        next_cmd.period = in_ch.period;
        next_cmd.slot   = in_ch.slot;
        want = timer_table_step(next_cmd);
        awaited_results.push_back(want);
        case (next_cmd.op)
          pts_pkg::OP_TICK:  begin
            n_tick++;
            if (want.fired_mask != '0) n_fire++;
          end
          pts_pkg::OP_SET:   begin
            n_set++;
            if (want.set_failed) n_set_fail++;
          end
          pts_pkg::OP_CLEAR: n_clear++;
          default:           n_clear_all++;
        endcase
      end
    end
  end

  // Watchdog: give up well beyond the slowest correct run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, awaited_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int unsigned r;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.opcode = pts_pkg::OP_TICK;
    in_ch.period = '0;
    in_ch.slot   = '0;
    out_ch.ready = 1'b0;
    errors       = 0;
    cycles       = 0;
    items_sent   = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    n_tick = 0; n_set = 0; n_set_fail = 0; n_fire = 0; n_clear = 0; n_clear_all = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_busy[i]   = 1'b0;
      slot_period[i] = '0;
      slot_count[i]  = '0;
    end

    // Directed: fill the table with extreme periods, overflow it, expire
    // slots, free a slot twice, reuse it, clear everything, clear a free slot
    queue_cmd(pts_pkg::OP_SET, 32'd1, '0);
    queue_cmd(pts_pkg::OP_SET, 32'hFFFF_FFFF, '0);
    queue_cmd(pts_pkg::OP_SET, 32'd0, '1);           // zero period: wraps, never fires here
    queue_cmd(pts_pkg::OP_SET, 32'd2, '0);
    queue_cmd(pts_pkg::OP_SET, 32'd3, '0);
    queue_cmd(pts_pkg::OP_SET, 32'h8000_0000, '0);
    queue_cmd(pts_pkg::OP_SET, 32'd5, '0);
    queue_cmd(pts_pkg::OP_SET, 32'h7FFF_FFFF, '0);
    queue_cmd(pts_pkg::OP_SET, 32'd4, '0);           // table full
    queue_cmd(pts_pkg::OP_TICK, '1, '1);
    queue_cmd(pts_pkg::OP_TICK, '0, '0);
    queue_cmd(pts_pkg::OP_TICK, '0, '0);
    queue_cmd(pts_pkg::OP_CLEAR, '0, 3'd7);
    queue_cmd(pts_pkg::OP_CLEAR, '0, 3'd7);          // already free
    queue_cmd(pts_pkg::OP_SET, 32'd6, '0);
    queue_cmd(pts_pkg::OP_CLEAR, '1, 3'd0);
    queue_cmd(pts_pkg::OP_TICK, '0, '0);
    queue_cmd(pts_pkg::OP_CLEAR_ALL, '1, '1);
    queue_cmd(pts_pkg::OP_TICK, '0, '0);
    queue_cmd(pts_pkg::OP_SET, 32'd1, '0);
    queue_cmd(pts_pkg::OP_TICK, '0, '0);
    queue_cmd(pts_pkg::OP_CLEAR, '0, 3'd5);

    // Random: tick-heavy mix so that short timers keep expiring and the table
    // keeps filling up and draining
    repeat (RANDOM_CMDS) begin
      r = $urandom_range(99);
      if (r < 55)
        queue_cmd(pts_pkg::OP_TICK, PERIOD_W'($urandom), SLOT_W'($urandom));
      else if (r < 80)
        queue_cmd(pts_pkg::OP_SET, pick_period(), SLOT_W'($urandom));
      else if (r < 97)
        queue_cmd(pts_pkg::OP_CLEAR, PERIOD_W'($urandom), SLOT_W'($urandom_range(7)));
      else
        queue_cmd(pts_pkg::OP_CLEAR_ALL, PERIOD_W'($urandom), SLOT_W'($urandom));
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain: every command offered and taken, every result checked
    while (cmd_queue.size() > 0 || in_ch.valid || awaited_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d ticks (%0d with expiries), %0d sets (%0d on a full table),",
             n_tick, n_fire, n_set, n_set_fail);
    $display("%0d single clears and %0d clear-alls, %0d errors", n_clear, n_clear_all, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
